/* rtl/bpq_pkg.sv */
// Package for the bounded priority queue: payload structs, codes and
// the control and scan-carry structs shared by the core and its cells.
// No dependencies.
package bpq_pkg;

  localparam int unsigned BPQ_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_OLDEST = 2'd0,
    MODE_MIN    = 2'd1,
    MODE_MAX    = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value_in;
  } bpq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic [FILL_W-1:0]        fill_count;
  } bpq_out_t;

  // Broadcast from the core to every cell.
  typedef struct packed {
    logic                     put_en;
    logic signed [DATA_W-1:0] put_value;
    logic                     shift_en;
    logic                     scan_min;
  } bpq_ctrl_t;

  // Scan word handed from cell to cell.
  typedef struct packed {
    logic                     tok;
    logic                     has;
    logic signed [DATA_W-1:0] best;
  } bpq_carry_t;

endpackage

/* rtl/bpq_cell.sv */
// One storage cell of the bounded priority queue: holds one entry, takes
// part in appends and close-up shifts, and does one compare of the scan.
// Depends on bpq_pkg.
module bpq_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bpq_pkg::bpq_ctrl_t             ctrl_i,
  input  logic [IDX_W-1:0]               shift_idx_i,
  input  logic                           prev_valid_i,
  input  logic                           next_valid_i,
  input  logic signed [bpq_pkg::DATA_W-1:0] next_value_i,
  input  bpq_pkg::bpq_carry_t            carry_i,
  input  logic [IDX_W-1:0]               carry_idx_i,
  output logic                           valid_o,
  output logic signed [bpq_pkg::DATA_W-1:0] value_o,
  output bpq_pkg::bpq_carry_t            carry_o,
  output logic [IDX_W-1:0]               carry_idx_o
);
  import bpq_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  bpq_carry_t               carry_q, carry_d;
  logic [IDX_W-1:0]         cidx_q, cidx_d;
  logic                     better;
  logic                     append;

  assign append = ctrl_i.put_en && prev_valid_i && !valid_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (append) begin
      valid_d = 1'b1;
      value_d = ctrl_i.put_value;
    end else if (ctrl_i.shift_en) begin
      // thermometer of valid bits loses its top cell
      valid_d = next_valid_i;
      if (MyIdx >= shift_idx_i) begin
        value_d = next_value_i;
      end
    end
  end

  // strict compare keeps the earliest entry on ties
  assign better = ctrl_i.scan_min ? (value_q < carry_i.best) : (value_q > carry_i.best);

  always_comb begin
    carry_d = carry_i;
    cidx_d  = carry_idx_i;
    if (carry_i.tok && valid_q && (!carry_i.has || better)) begin
      carry_d.has  = 1'b1;
      carry_d.best = value_q;
      cidx_d       = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    cidx_q  <= cidx_d;
  end

  assign valid_o     = valid_q;
  assign value_o     = value_q;
  assign carry_o     = carry_q;
  assign carry_idx_o = cidx_q;

endmodule

/* rtl/bounded_priority_queue_core.sv */
// Top level of the bounded priority queue: command decode, fill count,
// configuration registers and the row of bpq_cell storage cells.
// Depends on bpq_pkg and bpq_cell.
//
// Usage: raise start with a word on in_i (cmd put or take, value_in);
// the word is taken at a clock edge where busy is low. Each word gives
// exactly one result word on res_o, marked by res_valid_o for one cycle:
// status, removed value (0 unless a take succeeded) and the new count.
// Puts, refused operations and oldest-first takes finish at the accepting
// edge: the result shows in the next cycle and busy stays low, so one
// word per cycle. Smallest- or largest-first takes send a scan word down
// the cell row, one cell per cycle; busy is high while the scan runs, and
// the result is registered at the edge that drops busy, so the next word
// is taken only once busy is low. The removal and close-up of the gap
// happen together at the end of the scan.
// Configuration: cfg_we_i with cfg_idx_i (0 removal mode, 1 capacity) and
// cfg_wdata_i, written at once; write only while the queue is idle.
// Reset empties the queue, sets oldest-first mode and capacity 16.
// The receiver cannot stall; results are never held back.
module bounded_priority_queue_core #(
  parameter int unsigned DEPTH = bpq_pkg::BPQ_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  bpq_pkg::bpq_in_t                in_i,
  output logic                            busy,
  output logic                            res_valid_o,
  output bpq_pkg::bpq_out_t               res_o,
  input  logic                            cfg_we_i,
  input  logic [bpq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bpq_pkg::CFG_DAT_W-1:0]   cfg_wdata_i
);
  import bpq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > FILL_W) ? CntW : FILL_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [MODE_W-1:0] mode_q;
  logic [CAP_W-1:0]  cap_q;
  logic              rvalid_q, rvalid_d;
  bpq_out_t          res_q, res_d;

  bpq_ctrl_t         ctrl;
  logic [IdxW-1:0]   shift_idx;
  bpq_carry_t        head;
  logic              accept;
  logic              full;
  logic              sorted_take;
  logic [CmpW-1:0]   count_ext;
  logic [CmpW-1:0]   count_d_ext;

  logic                     valid   [DEPTH];
  logic signed [DATA_W-1:0] value   [DEPTH];
  bpq_carry_t               carry   [DEPTH];
  logic [IdxW-1:0]          cidx    [DEPTH];

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign count_ext   = CmpW'(count_q);
  assign full        = (count_ext >= CmpW'(cap_q)) || (count_ext >= CmpW'(DEPTH));
  assign sorted_take = (mode_q == MODE_MIN) || (mode_q == MODE_MAX);
  assign count_d_ext = CmpW'(count_d);

  assign head.tok  = accept && (in_i.cmd == CMD_TAKE) && (count_q != '0) && sorted_take;
  assign head.has  = 1'b0;
  assign head.best = '0;

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    rvalid_d       = 1'b0;
    res_d          = res_q;
    ctrl.put_en    = 1'b0;
    ctrl.put_value = in_i.value_in;
    ctrl.shift_en  = 1'b0;
    ctrl.scan_min  = (mode_q == MODE_MIN);
    shift_idx      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.status    = ST_DONE;
          res_d.value_out = '0;
          if (in_i.cmd == CMD_PUT) begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              ctrl.put_en = 1'b1;
              count_d     = count_q + CntW'(1);
            end
            rvalid_d = 1'b1;
          end else if (count_q == '0) begin
            res_d.status = ST_EMPTY;
            rvalid_d     = 1'b1;
          end else if (sorted_take) begin
            state_d = S_SCAN;
          end else begin
            // oldest first: drop the head cell
            ctrl.shift_en   = 1'b1;
            res_d.value_out = value[0];
            count_d         = count_q - CntW'(1);
            rvalid_d        = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (carry[DEPTH-1].tok) begin
          ctrl.shift_en   = 1'b1;
          shift_idx       = cidx[DEPTH-1];
          res_d.status    = ST_DONE;
          res_d.value_out = carry[DEPTH-1].best;
          count_d         = count_q - CntW'(1);
          rvalid_d        = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_d.fill_count = count_d_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      mode_q   <= MODE_OLDEST;
      cap_q    <= CAP_RESET;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q <= cfg_wdata_i[MODE_W-1:0];
          CFG_CAP:  cap_q  <= cfg_wdata_i[CAP_W-1:0];
          default: begin
            mode_q <= mode_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     prev_v;
    logic                     next_v;
    logic signed [DATA_W-1:0] next_val;
    bpq_carry_t               cin;
    logic [IdxW-1:0]          cin_idx;

    if (g == 0) begin : g_first
      assign prev_v  = 1'b1;
      assign cin     = head;
      assign cin_idx = '0;
    end else begin : g_mid
      assign prev_v  = valid[g-1];
      assign cin     = carry[g-1];
      assign cin_idx = cidx[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_v   = 1'b0;
      assign next_val = value[g];
    end else begin : g_inner
      assign next_v   = valid[g+1];
      assign next_val = value[g+1];
    end

    bpq_cell #(
      .CELL_IDX (g),
      .IDX_W    (IdxW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .shift_idx_i  (shift_idx),
      .prev_valid_i (prev_v),
      .next_valid_i (next_v),
      .next_value_i (next_val),
      .carry_i      (cin),
      .carry_idx_i  (cin_idx),
      .valid_o      (valid[g]),
      .value_o      (value[g]),
      .carry_o      (carry[g]),
      .carry_idx_o  (cidx[g])
    );
  end

  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for bounded_priority_queue_core: directed and random put/take
// traffic checked word by word against a queue predictor kept in the bench.
// Depends on bpq_pkg and the core RTL.
module tb;
  import bpq_pkg::*;

  localparam int unsigned DEPTH       = BPQ_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  bpq_in_t          in_i = '0;
  logic             busy;
  logic             res_valid_o;
  bpq_out_t         res_o;
  logic             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_MODE;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  // Predictor state: stored entries in arrival order plus the two registers.
  logic signed [DATA_W-1:0] stored_vals[$];
  mode_e                    mode_reg = MODE_OLDEST;
  logic [CAP_W-1:0]         cap_reg = CAP_RESET;
  bpq_out_t                 pending_res[$];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_refusals = 0;
  int unsigned empty_refusals = 0;
  int unsigned peak_fill = 0;
  int unsigned idle_pct = 0;

  bounded_priority_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_i        (in_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               pending_res.size());
      $display("bounded_priority_queue_core: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Compute the result word of one accepted command and update the store.
  function automatic bpq_out_t queue_step(input cmd_e c, input logic signed [DATA_W-1:0] v);
    bpq_out_t    r;
    int unsigned limit;
    int unsigned pick;
    r = '0;
    r.status = ST_DONE;
    limit = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    if (c == CMD_PUT) begin
      if (stored_vals.size() >= limit) begin
        r.status = ST_FULL;
      end else begin
        stored_vals.push_back(v);
      end
    end else if (stored_vals.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pick = 0;
      // Strict compare keeps the earliest entry on ties.
      if (mode_reg == MODE_MIN || mode_reg == MODE_MAX) begin
        for (int i = 1; i < stored_vals.size(); i++) begin
          if (mode_reg == MODE_MIN ? (stored_vals[i] < stored_vals[pick])
                                   : (stored_vals[i] > stored_vals[pick]))
            pick = i;
        end
      end
      r.value_out = stored_vals[pick];
      stored_vals.delete(pick);
    end
    r.fill_count = FILL_W'(stored_vals.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    bpq_out_t want;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", res_o));
      end else begin
        want = pending_res.pop_front();
        if (res_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", res_o.status, want.status));
        if (res_o.value_out !== want.value_out)
          report_mismatch($sformatf("value_out got %0d want %0d",
                                    res_o.value_out, want.value_out));
        if (res_o.fill_count !== want.fill_count)
          report_mismatch($sformatf("fill_count got %0d want %0d",
                                    res_o.fill_count, want.fill_count));
      end
    end
  end

  // Entered and left at a falling edge; start stays high for the caller.
  task automatic send_word(input cmd_e c, input logic signed [DATA_W-1:0] v);
    bpq_in_t  word;
    bpq_out_t r;
    // draw each idle cycle on its own so the idle share matches idle_pct
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_i  <= bpq_in_t'($urandom);
      @(negedge clk_i);
    end
    word.cmd      = c;
    word.value_in = v;
    start <= 1'b1;
    in_i  <= word;
    do @(posedge clk_i); while (busy);
    r = queue_step(c, v);
    pending_res.push_back(r);
    words_sent++;
    if (r.status == ST_FULL) full_refusals++;
    if (r.status == ST_EMPTY) empty_refusals++;
    if (stored_vals.size() > peak_fill) peak_fill = stored_vals.size();
    @(negedge clk_i);
  endtask

  // Drop start and hold until every expected word has come back.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_MODE) mode_reg = mode_e'(data[MODE_W-1:0]);
    else cap_reg = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4, 5: return $signed($urandom_range(8)) - 4;  // narrow range makes ties
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      4: return 5'd31;
      default: return CAP_W'($urandom_range(1, DEPTH));
    endcase
  endfunction

  // Mode ties, spare mode behaving as oldest first, extremes of the values.
  task automatic test_removal_modes();
    send_word(CMD_TAKE, 32'sd123);
    send_word(CMD_PUT, 32'sd5);
    send_word(CMD_PUT, 32'sh8000_0000);
    send_word(CMD_PUT, 32'sh7FFF_FFFF);
    send_word(CMD_PUT, 32'sd5);
    send_word(CMD_PUT, 32'sh8000_0000);
    send_word(CMD_PUT, 32'sd0);
    wait_idle();
    write_reg(CFG_MODE, {3'b000, MODE_MIN});
    send_word(CMD_TAKE, -32'sd1);
    send_word(CMD_TAKE, 32'sd0);
    wait_idle();
    write_reg(CFG_MODE, {3'b111, MODE_MAX});
    send_word(CMD_TAKE, 32'sd0);
    wait_idle();
    write_reg(CFG_MODE, {3'b101, MODE_SPARE});
    send_word(CMD_TAKE, 32'sd0);
    wait_idle();
    write_reg(CFG_MODE, {3'b000, MODE_OLDEST});
    send_word(CMD_TAKE, 32'sd0);
    wait_idle();
  endtask

  // Capacity lowered under the count, capacity one and capacity zero.
  task automatic test_capacity_limits();
    send_word(CMD_PUT, 32'sd7);
    wait_idle();
    write_reg(CFG_CAP, 5'd1);
    send_word(CMD_PUT, 32'sd9);
    send_word(CMD_TAKE, 32'sd0);
    send_word(CMD_PUT, 32'sd11);
    send_word(CMD_TAKE, 32'sd0);
    send_word(CMD_PUT, -32'sd2);
    send_word(CMD_PUT, 32'sd3);
    send_word(CMD_TAKE, 32'sd0);
    wait_idle();
    write_reg(CFG_CAP, 5'd0);
    send_word(CMD_PUT, 32'sd4);
    send_word(CMD_TAKE, 32'sd0);
    wait_idle();
  endtask

  // Phases of random traffic, each with its own mode, capacity and put mix.
  task automatic test_random_traffic(input int unsigned n_words, input int unsigned gap_pct);
    int unsigned done;
    int unsigned run;
    int unsigned put_bias;
    done = 0;
    idle_pct = gap_pct;
    while (done < n_words) begin
      wait_idle();
      write_reg(CFG_MODE, CFG_DAT_W'($urandom));
      write_reg(CFG_CAP, pick_capacity());
      put_bias = $urandom_range(20, 85);
      run = $urandom_range(20, 60);
      repeat (run) begin
        if ($urandom_range(99) < put_bias) send_word(CMD_PUT, pick_value());
        else send_word(CMD_TAKE, $urandom);
      end
      done += run;
    end
    idle_pct = 0;
  endtask

  initial begin
    int unsigned guard;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_removal_modes();
    test_capacity_limits();
    test_random_traffic(250, 8);
    test_random_traffic(250, 81);
    test_random_traffic(250, 0);

    start <= 1'b0;
    guard = 0;
    while (pending_res.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DEPTH + 4) @(posedge clk_i);
    if (pending_res.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_res.size()));

    $display("Run sent %0d words and checked %0d results in all removal modes,",
             words_sent, results_seen);
    $display("with %0d full and %0d empty refusals and a peak fill of %0d.",
             full_refusals, empty_refusals, peak_fill);
    if (errors == 0) begin
      $display("bounded_priority_queue_core: match");
    end else begin
      $display("bounded_priority_queue_core: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bpq_pkg.sv
rtl/bpq_cell.sv
rtl/bounded_priority_queue_core.sv
tb/tb.sv
